/* hw/rtl/servo_slew_positioner_macros.svh */
// ----------------------------------------------------------------------------
// servo slew positioner assertion macros
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SERVO_SLEW_POSITIONER_MACROS_SVH
`define SERVO_SLEW_POSITIONER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SSP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define SSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define SSP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// ssp_pkg
// shared types, constants and the midpoint function of the servo positioner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

    typedef enum logic [2:0] {
        MODE_TICK      = 3'd0,
        MODE_SET_STATE = 3'd1,
        MODE_OVERRIDE  = 3'd2,
        MODE_RELEASE   = 3'd3,
        MODE_INC       = 3'd4,
        MODE_DEC       = 3'd5,
        MODE_TOGGLE    = 3'd6,
        MODE_RESTORE   = 3'd7
    } ssp_mode_t;

    typedef enum logic [2:0] {
        CFG_STEP_INTERVAL = 3'd0,
        CFG_AUTO_RELEASE  = 3'd1,
        CFG_RELAY_PRESENT = 3'd2,
        CFG_DEFAULT_LOW   = 3'd3,
        CFG_DEFAULT_HIGH  = 3'd4
    } ssp_cfg_idx_t;

    localparam logic [7:0] STEP_INTERVAL_RST = 8'd20;
    localparam logic       AUTO_RELEASE_RST  = 1'b1;
    localparam logic       RELAY_PRESENT_RST = 1'b0;
    localparam logic [7:0] DEFAULT_LOW_RST   = 8'd45;
    localparam logic [7:0] DEFAULT_HIGH_RST  = 8'd135;

    // endpoint nudge bounds and step
    localparam logic [7:0] END_MAX  = 8'd174;
    localparam logic [7:0] END_MIN  = 8'd5;
    localparam logic [7:0] END_STEP = 8'd3;

    typedef struct packed {
        logic [7:0] step_interval;
        logic       auto_release;
        logic       relay_present;
        logic [7:0] default_low;
        logic [7:0] default_high;
    } ssp_cfg_t;

    typedef struct packed {
        logic [7:0] low_end;
        logic [7:0] high_end;
        logic [7:0] midpoint;
        logic [7:0] position;
        logic       target_high;
        logic       ovr_active;
        logic [7:0] ovr_target;
        logic       relay_invert;
        logic       relay_out;
        logic       motor_en;
        logic [7:0] elapsed;
    } ssp_state_t;

    // (hi - lo) / 2 rounded toward zero, plus lo, kept to 8 bits
    function automatic logic [7:0] ssp_midpoint(input logic [7:0] lo, input logic [7:0] hi);
        logic signed [9:0] span;
        logic signed [9:0] half;
        logic signed [9:0] sum;
        span = $signed({2'b00, hi}) - $signed({2'b00, lo});
        if (span < 10'sd0) begin
            half = (span + 10'sd1) >>> 1;
        end else begin
            half = span >>> 1;
        end
        sum = half + $signed({2'b00, lo});
        return sum[7:0];
    endfunction

    localparam logic [7:0] MIDPOINT_RST = ssp_midpoint(DEFAULT_LOW_RST, DEFAULT_HIGH_RST);

endpackage

`default_nettype wire

/* hw/rtl/ssp_step.sv */
// ----------------------------------------------------------------------------
// ssp_step
// next-state logic for one request: tick timing, slew step, relay and commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssp_step (
    input  ssp_pkg::ssp_state_t st,
    input  ssp_pkg::ssp_cfg_t   cfg,
    input  ssp_pkg::ssp_mode_t  mode,
    input  logic [7:0]          value,
    output ssp_pkg::ssp_state_t st_next,
    output logic                moved
);
    import ssp_pkg::*;

    logic [8:0] elapsed_inc;
    logic [7:0] goal;
    logic [7:0] pos_new;
    ssp_state_t nx;

    always_comb begin
        nx          = st;
        moved       = 1'b0;
        elapsed_inc = {1'b0, st.elapsed} + 9'd1;
        pos_new     = st.position;

        if (st.ovr_active) begin
            goal = st.ovr_target;
        end else if (st.target_high) begin
            goal = st.high_end;
        end else begin
            goal = st.low_end;
        end

        case (mode)
            MODE_TICK: begin
                if (elapsed_inc <= {1'b0, cfg.step_interval}) begin
                    nx.elapsed = elapsed_inc[7:0];
                end else begin
                    nx.elapsed = 8'd0;
                    // relay uses the position before the step
                    if (cfg.relay_present) begin
                        nx.relay_out = (st.position < st.midpoint)
                                     ^ (st.low_end > st.high_end)
                                     ^ st.relay_invert;
                    end
                    if (st.position < goal) begin
                        pos_new = st.position + 8'd1;
                    end else if (st.position > goal) begin
                        pos_new = st.position - 8'd1;
                    end
                    nx.position = pos_new;
                    if (pos_new != st.position) begin
                        moved = 1'b1;
                        if (pos_new != goal) begin
                            nx.motor_en = 1'b1;
                        end else if (cfg.auto_release) begin
                            nx.motor_en = 1'b0;
                        end
                    end
                end
            end
            MODE_SET_STATE: begin
                nx.target_high = (value != 8'd0);
            end
            MODE_OVERRIDE: begin
                nx.ovr_target = value;
                nx.ovr_active = 1'b1;
            end
            MODE_RELEASE: begin
                nx.ovr_active = 1'b0;
            end
            MODE_INC: begin
                if (st.target_high && st.high_end <= END_MAX) begin
                    nx.high_end = st.high_end + END_STEP;
                end else if (st.low_end <= END_MAX) begin
                    nx.low_end = st.low_end + END_STEP;
                end
            end
            MODE_DEC: begin
                if (st.target_high && st.high_end >= END_MIN) begin
                    nx.high_end = st.high_end - END_STEP;
                end else if (st.low_end >= END_MIN) begin
                    nx.low_end = st.low_end - END_STEP;
                end
            end
            MODE_TOGGLE: begin
                nx.relay_invert = ~st.relay_invert;
            end
            MODE_RESTORE: begin
                nx.low_end  = cfg.default_low;
                nx.high_end = cfg.default_high;
            end
            default: begin
                nx = st;
            end
        endcase

        // midpoint always follows the endpoints
        nx.midpoint = ssp_midpoint(nx.low_end, nx.high_end);
        st_next     = nx;
    end

endmodule

`default_nettype wire

/* hw/rtl/servo_slew_positioner.sv */
// ----------------------------------------------------------------------------
// servo_slew_positioner
// slew-limited servo positioner with endpoint trim, override and relay drive
// ----------------------------------------------------------------------------
// usage:
//   input channel s_valid/s_ready carries one request: s_mode and s_value.
//   mode tick is a millisecond tick; once the tick count exceeds step_interval
//   the position steps one degree toward its setpoint. other modes are commands.
//   every request yields exactly one result on m_valid/m_ready: position,
//   moved, relay level and motor enable after that request.
//   the result register loads at the accept edge and m_valid is high in the
//   next cycle. one request per cycle is accepted while results are taken,
//   set by the single state update feeding the result register.
//   when the receiver stalls, the result register holds and s_ready drops
//   until the result is taken; a request is accepted in the same cycle the
//   waiting result is taken.
//   cfg_wr_en/cfg_index/cfg_wdata write a register at once; write only idle.
//   synchronous active-low reset restores register defaults, puts the
//   position on the default low endpoint and empties the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "servo_slew_positioner_macros.svh"

module servo_slew_positioner (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_mode,
    input  logic [7:0] s_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_position,
    output logic       m_moved,
    output logic       m_relay_level,
    output logic       m_motor_on
);
    import ssp_pkg::*;

    ssp_cfg_t   cfg_reg;
    ssp_state_t st_reg;
    ssp_state_t st_next;
    logic       moved_next;
    logic       s_fire;

    logic       m_valid_reg;
    logic [7:0] m_position_reg;
    logic       m_moved_reg;
    logic       m_relay_reg;
    logic       m_motor_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    ssp_step u_step (
        .st      (st_reg),
        .cfg     (cfg_reg),
        .mode    (ssp_mode_t'(s_mode)),
        .value   (s_value),
        .st_next (st_next),
        .moved   (moved_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_interval <= STEP_INTERVAL_RST;
            cfg_reg.auto_release  <= AUTO_RELEASE_RST;
            cfg_reg.relay_present <= RELAY_PRESENT_RST;
            cfg_reg.default_low   <= DEFAULT_LOW_RST;
            cfg_reg.default_high  <= DEFAULT_HIGH_RST;
        end else if (cfg_wr_en) begin
            case (ssp_cfg_idx_t'(cfg_index))
                CFG_STEP_INTERVAL: cfg_reg.step_interval <= cfg_wdata;
                CFG_AUTO_RELEASE:  cfg_reg.auto_release  <= cfg_wdata[0];
                CFG_RELAY_PRESENT: cfg_reg.relay_present <= cfg_wdata[0];
                CFG_DEFAULT_LOW:   cfg_reg.default_low   <= cfg_wdata;
                CFG_DEFAULT_HIGH:  cfg_reg.default_high  <= cfg_wdata;
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.low_end      <= DEFAULT_LOW_RST;
            st_reg.high_end     <= DEFAULT_HIGH_RST;
            st_reg.midpoint     <= MIDPOINT_RST;
            st_reg.position     <= DEFAULT_LOW_RST;
            st_reg.target_high  <= 1'b0;
            st_reg.ovr_active   <= 1'b0;
            st_reg.ovr_target   <= 8'd0;
            st_reg.relay_invert <= 1'b0;
            st_reg.relay_out    <= 1'b0;
            st_reg.motor_en     <= 1'b0;
            st_reg.elapsed      <= 8'd0;
        end else if (s_fire) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded with each accepted request
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_position_reg <= st_next.position;
            m_moved_reg    <= moved_next;
            m_relay_reg    <= st_next.relay_out;
            m_motor_reg    <= st_next.motor_en;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_position    = m_position_reg;
    assign m_moved       = m_moved_reg;
    assign m_relay_level = m_relay_reg;
    assign m_motor_on    = m_motor_reg;

    `SSP_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !m_valid_reg, s_ready)
    `SSP_ASSERT_NEXT(a_slew_one_degree, aclk, aresetn, s_fire,
        (st_reg.position == $past(st_reg.position))
        || (st_reg.position == $past(st_reg.position) + 8'd1)
        || (st_reg.position == $past(st_reg.position) - 8'd1))
    `SSP_ASSERT_NEXT(a_cmd_no_move, aclk, aresetn, s_fire && (s_mode != MODE_TICK), !m_moved_reg)
    `SSP_ASSERT_NEXT(a_moved_matches, aclk, aresetn, s_fire,
        m_moved_reg == (st_reg.position != $past(st_reg.position)))
    `SSP_ASSERT_NEXT(a_idle_holds_state, aclk, aresetn, !s_fire, $stable(st_reg.position))

endmodule

`default_nettype wire
